FILE: sv/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg
// Shared types and constants of the transition table matcher: item action
// codes, port field widths and the result word.
// ----------------------------------------------------------------------------
package dtm_pkg;

	// fixed widths of the port fields
	localparam int STATE_W  = 6;
	localparam int ACTION_W = 3;
	localparam int SYM_W    = 8;

	// action codes of an input word
	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE  = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_MARK   = 3'd2,
		ACT_SYMBOL = 3'd3,
		ACT_END    = 3'd4
	} action_t;

	// one result word
	typedef struct packed {
		logic               accepted;
		logic               dead_end;
		logic [STATE_W-1:0] end_state;
	} res_t;

endpackage

FILE: sv/dtm_ram.sv
// ----------------------------------------------------------------------------
// dtm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: sv/dtm_clear.sv
// ----------------------------------------------------------------------------
// dtm_clear
// Clearing sequencer: after reset sweeps every table address once, one
// address per cycle, and then stays idle until the next reset.
// ----------------------------------------------------------------------------
module dtm_clear #(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [AW-1:0] addr
);

	logic [AW-1:0] cnt_q;
	logic          busy_q;

	// sweep counter, stops after the last address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q + AW'(1);
			if (cnt_q == {AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

FILE: sv/dtm_outq.sv
// ----------------------------------------------------------------------------
// dtm_outq
// Four-entry result queue between the matcher pipeline and the output
// channel; reports room for one more word counting the one still in flight.
// ----------------------------------------------------------------------------
module dtm_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtm_pkg::res_t  push_data,
	input  logic           pend,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output dtm_pkg::res_t  out_data
);

	import dtm_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int CNT_W = 3;

	res_t             buf_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = buf_q[rd_ptr_q];
	// an end word still in flight (pend) is counted before it lands here
	assign room      = (32'(cnt_q) + 32'(pend)) < DEPTH;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/dfa_transition_table_matcher.sv
// ----------------------------------------------------------------------------
// dfa_transition_table_matcher
// Table-driven automaton matcher: edits a transition table and accepting
// flags, runs symbol strings through them and reports one word per string.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle while in_stall is low, symbols
// included: a symbol issues a read of the transition table RAM, and the
// target state out of that RAM's read register is forwarded straight into
// the read address of the next symbol, so that RAM read plus a mux is the
// loop that sets the rate. Edits are single RAM writes. An end-of-string
// word reads the accepting-flag RAM and its result word reaches the output
// through a four-entry queue; past the clearing pass the input stalls only
// while that queue has no room. After reset a clearing pass writes every
// table entry and accepting flag, one per cycle, with in_stall held high;
// configuration writes are taken during the pass.
module dfa_transition_table_matcher #(
	parameter int NUM_STATES  = 64,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_wr_en,
	input  logic [dtm_pkg::STATE_W-1:0] cfg_wr_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [dtm_pkg::ACTION_W-1:0] action,
	input  logic [dtm_pkg::STATE_W-1:0] state_index,
	input  logic [dtm_pkg::SYM_W-1:0]   symbol,
	input  logic [dtm_pkg::STATE_W-1:0] next_state,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        accepted,
	output logic                        dead_end,
	output logic [dtm_pkg::STATE_W-1:0] end_state
);

	import dtm_pkg::*;

	localparam int ST_W   = $clog2(NUM_STATES);
	localparam int TAB_AW = ST_W + SYMBOL_BITS;
	localparam int ENT_W  = ST_W + 1;

	// configuration register
	logic [STATE_W-1:0] initial_q;

	// matcher state
	logic [ST_W-1:0]    cur_q;
	logic               start_q;
	logic               dead_q;
	logic               lk_s1;
	logic               end_s1;
	logic               end_dead_s1;
	logic               end_ok_s1;
	logic [STATE_W-1:0] end_fin_s1;

	// next values
	logic [ST_W-1:0]    cur_n;
	logic               start_n;
	logic               dead_n;
	logic               lk_n;
	logic               end_n;

	// ram ports
	logic               tab_en, tab_we;
	logic [TAB_AW-1:0]  tab_addr;
	logic [ENT_W-1:0]   tab_wdata, tab_rdata;
	logic               flag_en, flag_we;
	logic [ST_W-1:0]    flag_addr;
	logic [0:0]         flag_wdata, flag_rdata;

	// other
	logic               clr_busy;
	logic [TAB_AW-1:0]  clr_addr;
	logic               q_room;
	logic               in_take;
	logic [ST_W-1:0]    eff_cur;
	logic               eff_dead;
	logic [STATE_W-1:0] from_st;
	logic               from_ok, sidx_ok, nxt_ok;
	logic [SYMBOL_BITS-1:0] sym;
	res_t               res;

	// initial state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= '0;
		end else if (cfg_wr_en) begin
			initial_q <= cfg_wr_data;
		end
	end

	dtm_clear #(
		.AW(TAB_AW)
	) u_clear (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (clr_busy),
		.addr  (clr_addr)
	);

	assign in_stall = clr_busy || !q_room;
	assign in_take  = in_valid && !in_stall;

	// resolve a lookup still in flight: forward the table target
	assign eff_cur  = (lk_s1 && tab_rdata[ST_W]) ? tab_rdata[ST_W-1:0] : cur_q;
	assign eff_dead = dead_q || (lk_s1 && !tab_rdata[ST_W]);

	assign sym     = symbol[SYMBOL_BITS-1:0];
	assign from_st = start_q ? initial_q : STATE_W'(eff_cur);
	assign from_ok = 32'(from_st) < NUM_STATES;
	assign sidx_ok = 32'(state_index) < NUM_STATES;
	assign nxt_ok  = 32'(next_state) < NUM_STATES;

	// decode the input word into ram accesses and next state
	always_comb begin
		tab_en     = 1'b0;
		tab_we     = 1'b0;
		tab_addr   = {ST_W'(state_index), sym};
		tab_wdata  = '0;
		flag_en    = 1'b0;
		flag_we    = 1'b0;
		flag_addr  = ST_W'(state_index);
		flag_wdata = 1'b1;
		cur_n      = eff_cur;
		start_n    = start_q;
		dead_n     = eff_dead;
		lk_n       = 1'b0;
		end_n      = 1'b0;
		if (clr_busy) begin
			tab_en     = 1'b1;
			tab_we     = 1'b1;
			tab_addr   = clr_addr;
			flag_en    = 1'b1;
			flag_we    = 1'b1;
			flag_addr  = clr_addr[ST_W-1:0];
			flag_wdata = 1'b0;
		end else if (in_take) begin
			unique case (action_t'(action))
				ACT_WRITE: begin
					if (sidx_ok && nxt_ok) begin
						tab_en    = 1'b1;
						tab_we    = 1'b1;
						tab_wdata = {1'b1, ST_W'(next_state)};
					end
				end
				ACT_REMOVE: begin
					if (sidx_ok) begin
						tab_en = 1'b1;
						tab_we = 1'b1;
					end
				end
				ACT_MARK: begin
					if (sidx_ok) begin
						flag_en = 1'b1;
						flag_we = 1'b1;
					end
				end
				ACT_SYMBOL: begin
					start_n = 1'b0;
					if (!eff_dead) begin
						if (!from_ok) begin
							dead_n = 1'b1;
						end else begin
							tab_en   = 1'b1;
							tab_addr = {ST_W'(from_st), sym};
							lk_n     = 1'b1;
						end
					end
				end
				ACT_END: begin
					flag_en   = 1'b1;
					flag_addr = ST_W'(from_st);
					end_n     = 1'b1;
					cur_n     = '0;
					start_n   = 1'b1;
					dead_n    = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// string state and stage-one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			start_q <= 1'b1;
			dead_q  <= 1'b0;
			lk_s1   <= 1'b0;
			end_s1  <= 1'b0;
		end else begin
			cur_q   <= cur_n;
			start_q <= start_n;
			dead_q  <= dead_n;
			lk_s1   <= lk_n;
			end_s1  <= end_n;
		end
	end

	// end-of-string payload carried to stage one
	always_ff @(posedge clk) begin
		if (end_n) begin
			end_dead_s1 <= eff_dead;
			end_ok_s1   <= from_ok;
			end_fin_s1  <= from_st;
		end
	end

	dtm_ram #(
		.WIDTH(ENT_W),
		.DEPTH(1 << TAB_AW)
	) u_table (
		.clk  (clk),
		.en   (tab_en),
		.we   (tab_we),
		.addr (tab_addr),
		.wdata(tab_wdata),
		.rdata(tab_rdata)
	);

	dtm_ram #(
		.WIDTH(1),
		.DEPTH(1 << ST_W)
	) u_flags (
		.clk  (clk),
		.en   (flag_en),
		.we   (flag_we),
		.addr (flag_addr),
		.wdata(flag_wdata),
		.rdata(flag_rdata)
	);

	// result word from the flag read
	always_comb begin
		res.accepted  = !end_dead_s1 && end_ok_s1 && flag_rdata[0];
		res.dead_end  = end_dead_s1;
		res.end_state = end_dead_s1 ? '0 : end_fin_s1;
	end

	res_t out_res;

	dtm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (end_s1),
		.push_data(res),
		.pend     (end_s1),
		.room     (q_room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_res)
	);

	assign accepted  = out_res.accepted;
	assign dead_end  = out_res.dead_end;
	assign end_state = out_res.end_state;

endmodule

FILE: bench/dtm_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtm_match_checker
// Watches the input, output and start-state ports of the matcher, keeps its
// own copy of the automaton and scores every result word in order.
// ----------------------------------------------------------------------------
module dtm_match_checker #(
	parameter int NUM_STATES  = 64,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dtm_pkg::STATE_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [dtm_pkg::ACTION_W-1:0] action,
	input  logic [dtm_pkg::STATE_W-1:0]  state_index,
	input  logic [dtm_pkg::SYM_W-1:0]    symbol,
	input  logic [dtm_pkg::STATE_W-1:0]  next_state,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         accepted,
	input  logic                         dead_end,
	input  logic [dtm_pkg::STATE_W-1:0]  end_state,
	output int                           failures,
	output int                           outstanding
);

	localparam int SW = dtm_pkg::STATE_W;
	localparam int YW = dtm_pkg::SYM_W;
	localparam int SLOTS = 1 << (SW + YW);
	localparam logic [YW-1:0] SYM_MASK = YW'((1 << SYMBOL_BITS) - 1);

	// arc entry: valid mark on top, target state below
	bit [SW:0]        arc_tbl [SLOTS];
	bit               accept_flag [1 << SW];
	logic [SW-1:0]    start_reg;
	logic [SW-1:0]    walk_state;
	bit               walk_fresh;
	bit               walk_dead;
	dtm_pkg::res_t    verdict_q [$];
	int               err_count = 0;

	assign failures = err_count;

	function automatic bit state_ok(input logic [SW-1:0] s);
		return int'(s) < NUM_STATES;
	endfunction

	// advance the automaton copy by one accepted word
	task automatic predict_word(input logic [dtm_pkg::ACTION_W-1:0] act,
			input logic [SW-1:0] sidx, input logic [YW-1:0] sym,
			input logic [SW-1:0] nxt);
		logic [YW-1:0] masked;
		logic [SW-1:0] from;
		bit [SW:0]     arc;
		dtm_pkg::res_t want;
		masked = sym & SYM_MASK;
		from = walk_fresh ? start_reg : walk_state;
		case (act)
			dtm_pkg::ACT_WRITE: begin
				if (state_ok(sidx) && state_ok(nxt))
					arc_tbl[{sidx, masked}] = {1'b1, nxt};
			end
			dtm_pkg::ACT_REMOVE: begin
				if (state_ok(sidx))
					arc_tbl[{sidx, masked}] = '0;
			end
			dtm_pkg::ACT_MARK: begin
				if (state_ok(sidx))
					accept_flag[sidx] = 1'b1;
			end
			dtm_pkg::ACT_SYMBOL: begin
				walk_fresh = 1'b0;
				// a dead string swallows symbols until its end
				if (!walk_dead) begin
					if (!state_ok(from)) begin
						walk_dead = 1'b1;
					end else begin
						arc = arc_tbl[{from, masked}];
						if (!arc[SW])
							walk_dead = 1'b1;
						else
							walk_state = arc[SW-1:0];
					end
				end
			end
			dtm_pkg::ACT_END: begin
				want.accepted  = !walk_dead && state_ok(from) && accept_flag[from];
				want.dead_end  = walk_dead;
				want.end_state = walk_dead ? '0 : from;
				verdict_q.push_back(want);
				walk_state = '0;
				walk_fresh = 1'b1;
				walk_dead  = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [SW-1:0] want,
			input logic [SW-1:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// score one result word against the oldest expectation
	task automatic score_result();
		dtm_pkg::res_t want;
		if (verdict_q.size() == 0) begin
			err_count++;
			$display("%0t: result word with none expected, actual %0b/%0b/%0d",
				$time, accepted, dead_end, end_state);
		end else begin
			want = verdict_q.pop_front();
			compare_field("accepted", {5'd0, want.accepted}, {5'd0, accepted});
			compare_field("dead_end", {5'd0, want.dead_end}, {5'd0, dead_end});
			compare_field("end_state", want.end_state, end_state);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (arc_tbl[i]) arc_tbl[i] = '0;
			foreach (accept_flag[i]) accept_flag[i] = 1'b0;
			start_reg  = '0;
			walk_state = '0;
			walk_fresh = 1'b1;
			walk_dead  = 1'b0;
			verdict_q.delete();
			outstanding <= 0;
		end else begin
			// results first: a word taken at this edge cannot answer yet
			if (out_valid && !out_stall)
				score_result();
			if (cfg_wr_en)
				start_reg = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_word(action, state_index, symbol, next_state);
			outstanding <= verdict_q.size();
		end
	end

endmodule

FILE: bench/dfa_transition_table_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfa_transition_table_matcher_tb
// Drives edit and string words into the matcher under three stall mixes and
// four start states; the checker beside the block predicts and scores results.
// ----------------------------------------------------------------------------
module dfa_transition_table_matcher_tb;
	import dtm_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [STATE_W-1:0]  cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ACTION_W-1:0] action = '0;
	logic [STATE_W-1:0]  state_index = '0;
	logic [SYM_W-1:0]    symbol = '0;
	logic [STATE_W-1:0]  next_state = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                accepted;
	logic                dead_end;
	logic [STATE_W-1:0]  end_state;

	int failures;
	int outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int words_sent = 0;
	int strings_sent = 0;
	int cycle_count = 0;
	logic [STATE_W-1:0] start_now = '0;
	logic [STATE_W-1:0] mid_start;
	logic [STATE_W-1:0] last_start;
	logic [STATE_W-1:0] pool [8];
	logic [SYM_W-1:0]   alpha [4];

	dfa_transition_table_matcher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.state_index (state_index),
		.symbol      (symbol),
		.next_state  (next_state),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.dead_end    (dead_end),
		.end_state   (end_state)
	);

	dtm_match_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.state_index (state_index),
		.symbol      (symbol),
		.next_state  (next_state),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.dead_end    (dead_end),
		.end_state   (end_state),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// present one word, with random idle cycles ahead of it, until taken
	task automatic send_word(input logic [ACTION_W-1:0] act, input logic [STATE_W-1:0] sidx,
			input logic [SYM_W-1:0] sym, input logic [STATE_W-1:0] nxt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		state_index <= sidx;
		symbol      <= sym;
		next_state  <= nxt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (act <= ACT_END)
			words_sent++;
		if (act == ACT_END)
			strings_sent++;
	endtask

	// hold the sender until every result word is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// new start state, written only with the block idle
	task automatic set_start(input logic [STATE_W-1:0] v);
		drain();
		repeat (6) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		start_now = v;
	endtask

	function automatic logic [STATE_W-1:0] pick_state();
		return ($urandom_range(99) < 80) ? pool[$urandom_range(7)] : STATE_W'($urandom);
	endfunction

	function automatic logic [SYM_W-1:0] pick_sym();
		return ($urandom_range(99) < 80) ? alpha[$urandom_range(3)] : SYM_W'($urandom);
	endfunction

	// one string of len symbols, with an occasional edit slipped in mid-string
	task automatic run_string(input int len);
		int k;
		int r;
		for (k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (r < 8)
				send_word(ACT_WRITE, pick_state(), pick_sym(), pick_state());
			else if (r < 11)
				send_word(ACT_REMOVE, pick_state(), pick_sym(), STATE_W'($urandom));
			send_word(ACT_SYMBOL, STATE_W'($urandom), (r < 88) ? alpha[$urandom_range(3)]
				: SYM_W'($urandom), STATE_W'($urandom));
		end
		send_word(ACT_END, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom));
	endtask

	// edges of the fields, empty strings, dead ends and mid-string edits
	task automatic directed_checks();
		send_word(ACT_END, 6'd0, 8'h00, 6'd0);
		send_word(ACT_MARK, 6'd0, 8'h00, 6'd0);
		send_word(ACT_END, 6'h3F, 8'hFF, 6'h3F);
		send_word(ACT_WRITE, 6'd0, 8'h00, 6'h3F);
		send_word(ACT_WRITE, 6'h3F, 8'hFF, 6'd0);
		send_word(ACT_SYMBOL, 6'd0, 8'h00, 6'd0);
		send_word(ACT_SYMBOL, 6'h3F, 8'hFF, 6'h3F);
		send_word(ACT_END, 6'd0, 8'h00, 6'd0);
		send_word(ACT_SYMBOL, 6'd0, 8'h00, 6'd0);
		send_word(ACT_END, 6'd0, 8'h00, 6'd0);
		send_word(ACT_MARK, 6'h3F, 8'h00, 6'd0);
		send_word(ACT_SYMBOL, 6'd0, 8'h00, 6'd0);
		send_word(ACT_END, 6'd0, 8'h00, 6'd0);
		// removed arc kills the string, later symbols have no effect
		send_word(ACT_REMOVE, 6'd0, 8'h00, 6'h3F);
		send_word(ACT_SYMBOL, 6'd0, 8'h00, 6'd0);
		send_word(ACT_SYMBOL, 6'd0, 8'hFF, 6'd0);
		send_word(ACT_END, 6'h3F, 8'hFF, 6'h3F);
		// unused action codes
		send_word(3'd5, 6'h3F, 8'hFF, 6'h3F);
		send_word(3'd6, 6'h3F, 8'hFF, 6'h3F);
		send_word(3'd7, 6'h3F, 8'hFF, 6'h3F);
		// arcs written while the string is running
		send_word(ACT_WRITE, 6'd0, 8'hA5, 6'h2A);
		send_word(ACT_SYMBOL, 6'd0, 8'hA5, 6'd0);
		send_word(ACT_WRITE, 6'h2A, 8'h5A, 6'd0);
		send_word(ACT_SYMBOL, 6'd0, 8'h5A, 6'd0);
		send_word(ACT_END, 6'd0, 8'h00, 6'd0);
	endtask

	// mostly well-formed strings over a small automaton, plus edits and noise
	task automatic random_phase(input int quota);
		int first;
		int i;
		int r;
		bit paused;
		first = words_sent;
		paused = 1'b0;
		pool[0] = start_now;
		for (i = 1; i < 8; i++) pool[i] = STATE_W'($urandom);
		for (i = 0; i < 4; i++) alpha[i] = SYM_W'($urandom);
		// chain out of the start state so strings get past the first symbol
		for (i = 0; i < 7; i++) send_word(ACT_WRITE, pool[i], alpha[i % 4], pool[i + 1]);
		repeat (12) send_word(ACT_WRITE, pool[$urandom_range(7)], alpha[$urandom_range(3)],
			pool[$urandom_range(7)]);
		send_word(ACT_MARK, pool[$urandom_range(1, 7)], SYM_W'($urandom), STATE_W'($urandom));
		while (words_sent - first < quota) begin
			r = $urandom_range(99);
			if (r < 62)
				run_string(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8));
			else if (r < 76)
				send_word(ACT_WRITE, pick_state(), pick_sym(), pick_state());
			else if (r < 83)
				send_word(ACT_REMOVE, pick_state(), pick_sym(), STATE_W'($urandom));
			else if (r < 86)
				send_word(ACT_MARK, ($urandom_range(1) == 0) ? pool[$urandom_range(7)]
					: STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom));
			else if (r < 93)
				send_word(ACT_SYMBOL, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom));
			else if (r < 96)
				send_word(ACT_END, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom));
			else
				send_word(ACTION_W'($urandom_range(5, 7)), STATE_W'($urandom),
					SYM_W'($urandom), STATE_W'($urandom));
			if (!paused && words_sent - first >= quota / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		set_start(6'd0);
		directed_checks();

		set_start(6'h3F);
		send_idle_pct = 21;
		recv_idle_pct = 83;
		random_phase(415);

		mid_start = STATE_W'($urandom_range(1, 62));
		set_start(mid_start);
		send_idle_pct = 83;
		recv_idle_pct = 21;
		random_phase(415);

		last_start = STATE_W'($urandom);
		set_start(last_start);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(420);

		drain();
		repeat (10) @(posedge clk);
		$display("run covered %0d words and %0d strings, start states 0, 63, %0d and %0d",
			words_sent, strings_sent, mid_start, last_start);
		$display("stall mixes: light sender/heavy receiver, the reverse, then none");
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
sv/dtm_pkg.sv
sv/dtm_ram.sv
sv/dtm_clear.sv
sv/dtm_outq.sv
sv/dfa_transition_table_matcher.sv
bench/dtm_match_checker.sv
bench/dfa_transition_table_matcher_tb.sv
